>>> rtl/kmi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyframe matrix interpolator.
// No dependencies.
package kmi_pkg;

  localparam int unsigned PAIRS   = 8;
  localparam int unsigned PAIR_W  = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PROG_W  = 16;
  localparam int unsigned DVD_W   = WORD_W + PROG_W;
  localparam logic [31:0] Q_ONE   = 32'h0001_0000;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] pair_t;
  typedef logic [PROG_W-1:0]   prog_t;
  typedef logic [PAIR_W-1:0]   pidx_t;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;
    word_t               divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    prog_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

>>> rtl/kmi_div.sv
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on kmi_pkg.
module kmi_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kmi_pkg::div_req_t req_i,
  output kmi_pkg::div_rsp_t rsp_o
);
  import kmi_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  word_t            dvs_q;
  word_t            rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WORD_W:0]  rem_sh;
  logic [WORD_W:0]  rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = !rem_sub[WORD_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q[PROG_W-1:0];
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/kmi_blend.sv
`timescale 1ns / 1ps
// Shared blend unit: a + floor((b - a) * p / 65536), one element per cycle.
// Depends on kmi_pkg.
module kmi_blend (
  input  logic          clk_i,
  input  kmi_pkg::word_t a_i,
  input  kmi_pkg::word_t b_i,
  input  kmi_pkg::prog_t p_i,
  output kmi_pkg::word_t res_o
);
  import kmi_pkg::*;

  logic signed [WORD_W:0]          diff;
  logic signed [PROG_W:0]          ps;
  logic signed [WORD_W+PROG_W+1:0] prod;
  logic signed [WORD_W+PROG_W+1:0] prod_q;
  word_t                           a_q;

  assign diff = $signed({b_i[WORD_W-1], b_i}) - $signed({a_i[WORD_W-1], a_i});
  assign ps   = $signed({1'b0, p_i});
  assign prod = diff * ps;

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    a_q    <= a_i;
  end

  assign res_o = a_q + word_t'(prod_q[WORD_W+PROG_W-1:PROG_W]);

endmodule

>>> rtl/keyframe_matrix_interpolator.sv
`timescale 1ns / 1ps
// An add request searches the stored keys, shifts the later keys up by one slot and then
// writes the new key; an evaluate wraps the time, searches the keys, divides for the
// progress and blends each pair, using the one shared serial divider, the single blend
// multiplier and the key memories.
// Depends on kmi_pkg, kmi_div and kmi_blend.
module keyframe_matrix_interpolator #(
  parameter int unsigned MAX_KEYS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  kmi_pkg::word_t cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          func_i,
  input  kmi_pkg::word_t key_time_i,
  input  kmi_pkg::pair_t in_pair_0_i,
  input  kmi_pkg::pair_t in_pair_1_i,
  input  kmi_pkg::pair_t in_pair_2_i,
  input  kmi_pkg::pair_t in_pair_3_i,
  input  kmi_pkg::pair_t in_pair_4_i,
  input  kmi_pkg::pair_t in_pair_5_i,
  input  kmi_pkg::pair_t in_pair_6_i,
  input  kmi_pkg::pair_t in_pair_7_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          status_o,
  output kmi_pkg::pair_t out_pair_0_o,
  output kmi_pkg::pair_t out_pair_1_o,
  output kmi_pkg::pair_t out_pair_2_o,
  output kmi_pkg::pair_t out_pair_3_o,
  output kmi_pkg::pair_t out_pair_4_o,
  output kmi_pkg::pair_t out_pair_5_o,
  output kmi_pkg::pair_t out_pair_6_o,
  output kmi_pkg::pair_t out_pair_7_o
);
  import kmi_pkg::*;

  localparam int unsigned KW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned EW = KW + PAIR_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_WRAPW = 5'd2;
  localparam logic [4:0] S_PRE   = 5'd3;
  localparam logic [4:0] S_SRD   = 5'd4;
  localparam logic [4:0] S_SCMP  = 5'd5;
  localparam logic [4:0] S_SEND  = 5'd6;
  localparam logic [4:0] S_SHRD  = 5'd7;
  localparam logic [4:0] S_SHWR  = 5'd8;
  localparam logic [4:0] S_WRN   = 5'd9;
  localparam logic [4:0] S_CRD   = 5'd10;
  localparam logic [4:0] S_CWR   = 5'd11;
  localparam logic [4:0] S_T1RD  = 5'd12;
  localparam logic [4:0] S_T1W   = 5'd13;
  localparam logic [4:0] S_DIVW  = 5'd14;
  localparam logic [4:0] S_BRD   = 5'd15;
  localparam logic [4:0] S_BLO   = 5'd16;
  localparam logic [4:0] S_BHI   = 5'd17;
  localparam logic [4:0] S_BWR   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0]    state_q, state_d;
  word_t         loop_len_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] sh_i_q;
  logic [KW-1:0] ckey_q;
  pidx_t         j_q;
  logic          func_q;
  logic          eq_q;
  word_t         t_q;
  word_t         t2_q;
  prog_t         p_q;
  pair_t         inp_q [PAIRS];
  pair_t         out_q [PAIRS];
  logic          status_q;

  word_t         tmem [MAX_KEYS];
  pair_t         emem [MAX_KEYS*PAIRS];
  word_t         tm_rd_q;
  pair_t         ea_q;
  pair_t         eb_q;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] i_m1;
  logic [KW-1:0] tm_raddr;
  logic [EW-1:0] ea_addr;
  logic [EW-1:0] eb_addr;
  logic          tm_we;
  logic [KW-1:0] tm_waddr;
  word_t         tm_wdata;
  logic          em_we;
  logic [EW-1:0] em_waddr;
  pair_t         em_wdata;

  div_req_t      div_req;
  div_rsp_t      div_rsp;
  word_t         bl_a;
  word_t         bl_b;
  word_t         bl_res;
  logic          hit;
  logic          last_pair;

  assign idx_m1    = idx_q - 1'b1;
  assign i_m1      = sh_i_q - 1'b1;
  assign last_pair = (j_q == PAIR_W'(PAIRS - 1));
  assign hit       = (tm_rd_q > t_q) || (!func_q && (tm_rd_q == t_q));

  always_comb begin
    case (state_q)
      S_T1RD:  tm_raddr = idx_m1[KW-1:0];
      S_SHRD:  tm_raddr = i_m1[KW-1:0];
      default: tm_raddr = idx_q[KW-1:0];
    endcase
    case (state_q)
      S_SHRD:  ea_addr = {i_m1[KW-1:0], j_q};
      S_CRD:   ea_addr = {ckey_q, j_q};
      default: ea_addr = {idx_m1[KW-1:0], j_q};
    endcase
    eb_addr = {idx_q[KW-1:0], j_q};
  end

  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = idx_q[KW-1:0];
    tm_wdata = t_q;
    em_we    = 1'b0;
    em_waddr = {idx_q[KW-1:0], j_q};
    em_wdata = inp_q[j_q];
    case (state_q)
      S_SHWR: begin
        em_we    = 1'b1;
        em_waddr = {sh_i_q[KW-1:0], j_q};
        em_wdata = ea_q;
        tm_we    = (j_q == '0);
        tm_waddr = sh_i_q[KW-1:0];
        tm_wdata = tm_rd_q;
      end
      S_WRN: begin
        em_we = 1'b1;
        tm_we = (j_q == '0);
      end
      default: begin
        em_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) begin
      tmem[tm_waddr] <= tm_wdata;
    end
    if (em_we) begin
      emem[em_waddr] <= em_wdata;
    end
    tm_rd_q <= tmem[tm_raddr];
    ea_q    <= emem[ea_addr];
    eb_q    <= emem[eb_addr];
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {{PROG_W{1'b0}}, t_q};
    div_req.divisor  = loop_len_q;
    case (state_q)
      S_START: begin
        div_req.start = func_q && (loop_len_q != '0);
      end
      S_T1W: begin
        div_req.start    = 1'b1;
        div_req.dividend = {t_q - tm_rd_q, {PROG_W{1'b0}}};
        div_req.divisor  = t2_q - tm_rd_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  kmi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign bl_a = (state_q == S_BHI) ? ea_q[2*WORD_W-1:WORD_W] : ea_q[WORD_W-1:0];
  assign bl_b = (state_q == S_BHI) ? eb_q[2*WORD_W-1:WORD_W] : eb_q[WORD_W-1:0];

  kmi_blend u_blend (
    .clk_i (clk_i),
    .a_i   (bl_a),
    .b_i   (bl_b),
    .p_i   (p_q),
    .res_o (bl_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_START;
      S_START: state_d = div_req.start ? S_WRAPW : S_PRE;
      S_WRAPW: if (div_rsp.done) state_d = S_PRE;
      S_PRE:   state_d = (func_q && (count_q == '0)) ? S_DONE : S_SRD;
      S_SRD:   state_d = (idx_q == count_q) ? S_SEND : S_SCMP;
      S_SCMP:  state_d = hit ? S_SEND : S_SRD;
      S_SEND: begin
        if (!func_q) begin
          if (eq_q) state_d = S_WRN;
          else if (count_q == CW'(MAX_KEYS)) state_d = S_DONE;
          else state_d = S_SHRD;
        end else if ((idx_q == count_q) || (idx_q == '0)) begin
          state_d = S_CRD;
        end else begin
          state_d = S_T1RD;
        end
      end
      S_SHRD:  state_d = (sh_i_q == idx_q) ? S_WRN : S_SHWR;
      S_SHWR:  state_d = S_SHRD;
      S_WRN:   if (last_pair) state_d = S_DONE;
      S_CRD:   state_d = S_CWR;
      S_CWR:   state_d = last_pair ? S_DONE : S_CRD;
      S_T1RD:  state_d = S_T1W;
      S_T1W:   state_d = S_DIVW;
      S_DIVW:  if (div_rsp.done) state_d = S_BRD;
      S_BRD:   state_d = S_BLO;
      S_BLO:   state_d = S_BHI;
      S_BHI:   state_d = S_BWR;
      S_BWR:   state_d = last_pair ? S_DONE : S_BRD;
      S_DONE:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      loop_len_q <= '0;
      count_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        loop_len_q <= cfg_wdata_i;
      end
      if (state_q == S_WRN && last_pair && !eq_q) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        func_q   <= func_i;
        t_q      <= key_time_i;
        inp_q[0] <= in_pair_0_i;
        inp_q[1] <= in_pair_1_i;
        inp_q[2] <= in_pair_2_i;
        inp_q[3] <= in_pair_3_i;
        inp_q[4] <= in_pair_4_i;
        inp_q[5] <= in_pair_5_i;
        inp_q[6] <= in_pair_6_i;
        inp_q[7] <= in_pair_7_i;
        status_q <= 1'b0;
        for (int k = 0; k < PAIRS; k++) begin
          out_q[k] <= '0;
        end
      end
      S_WRAPW: begin
        if (div_rsp.done) t_q <= div_rsp.remainder;
      end
      S_PRE: begin
        idx_q <= '0;
        eq_q  <= 1'b0;
        if (func_q && (count_q == '0)) begin
          out_q[0] <= {32'h0, Q_ONE};
          out_q[2] <= {Q_ONE, 32'h0};
          out_q[5] <= {32'h0, Q_ONE};
          out_q[7] <= {Q_ONE, 32'h0};
        end
      end
      S_SCMP: begin
        if (hit) begin
          t2_q <= tm_rd_q;
          eq_q <= (tm_rd_q == t_q);
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_SEND: begin
        j_q    <= '0;
        sh_i_q <= count_q;
        ckey_q <= (idx_q == count_q) ? idx_m1[KW-1:0] : '0;
        if (!func_q && !eq_q && (count_q == CW'(MAX_KEYS))) status_q <= 1'b1;
      end
      S_SHWR: begin
        j_q <= j_q + 1'b1;
        if (last_pair) sh_i_q <= i_m1;
      end
      S_WRN: j_q <= j_q + 1'b1;
      S_CWR: begin
        out_q[j_q] <= ea_q;
        j_q        <= j_q + 1'b1;
      end
      S_DIVW: begin
        p_q <= div_rsp.quotient;
        j_q <= '0;
      end
      S_BHI: out_q[j_q][WORD_W-1:0] <= bl_res;
      S_BWR: begin
        out_q[j_q][2*WORD_W-1:WORD_W] <= bl_res;
        j_q <= j_q + 1'b1;
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_DONE);
  assign status_o     = status_q;
  assign out_pair_0_o = out_q[0];
  assign out_pair_1_o = out_q[1];
  assign out_pair_2_o = out_q[2];
  assign out_pair_3_o = out_q[3];
  assign out_pair_4_o = out_q[4];
  assign out_pair_5_o = out_q[5];
  assign out_pair_6_o = out_q[6];
  assign out_pair_7_o = out_q[7];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("Key count exceeds table size.");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_full_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (!func_q && count_q == CW'(MAX_KEYS)))
    else $error("Full status on a request that cannot overflow.");

  a_count_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_WRN && !$past(func_q)))
    else $error("Key count changed outside an insert.");

endmodule
